[rtl/midi_note_voice_splitter_top_defines.svh]
// Assertion macros used by the splitter top.
`ifndef MIDI_NOTE_VOICE_SPLITTER_TOP_DEFINES_SVH
`define MIDI_NOTE_VOICE_SPLITTER_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define MNVS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// property that also holds across reset
`define MNVS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/mnvs_pkg.sv]
`default_nettype none

package mnvs_pkg;

   // sizes
   localparam int VOICES     = 128;
   localparam int PITCHES    = 128;
   localparam int VOICE_W    = 7;
   localparam int PITCH_W    = 7;
   localparam int OPEN_W     = 8;
   localparam int TIME_W     = 32;
   localparam int DELTA_W    = 28;
   localparam int VEL_W      = 7;
   localparam int TEMPO_W    = 24;
   localparam int KIND_W     = 3;
   localparam int RKIND_W    = 2;
   localparam int NPITCH_W   = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   localparam logic [OPEN_W-1:0] OPEN_MAX = OPEN_W'(VOICES);

   // free-voice search: groups of eight, one registered level
   localparam int GROUP_SIZE = 8;
   localparam int GROUPS     = VOICES / GROUP_SIZE;
   localparam int LIDX_W     = 3;
   localparam int GIDX_W     = VOICE_W - LIDX_W;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TEMPO    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd3;

   // record kinds
   localparam logic [RKIND_W-1:0] REC_NOTE  = 2'd0;
   localparam logic [RKIND_W-1:0] REC_REST  = 2'd1;
   localparam logic [RKIND_W-1:0] REC_TEMPO = 2'd2;
   localparam logic [RKIND_W-1:0] REC_END   = 2'd3;

   localparam logic [NPITCH_W-1:0] REST_CODE = 8'd128;

   typedef struct packed {
      logic [RKIND_W-1:0]  kind;
      logic [VOICE_W-1:0]  voice;
      logic [NPITCH_W-1:0] note_pitch;
      logic [TIME_W-1:0]   length;
      logic [TEMPO_W-1:0]  tempo;
      logic                last;
   } rec_type;

   typedef struct packed {
      logic                rd_en;
      logic [PITCH_W-1:0]  addr;
      logic                set;      // note start: mark held, write entry
      logic                clr;      // release: drop held mark
      logic                clr_all;
      logic [VOICE_W-1:0]  wr_voice;
      logic [TIME_W-1:0]   wr_start;
   } pitch_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [VOICE_W-1:0]  voice;
      logic [TIME_W-1:0]   start;
   } pitch_stat_type;

   typedef struct packed {
      logic                rd_en;
      logic [VOICE_W-1:0]  rd_addr;
      logic                wr_en;
      logic [VOICE_W-1:0]  wr_addr;
      logic [TIME_W-1:0]   wr_data;
      logic                take;     // voice becomes busy
      logic                give;     // voice becomes free
      logic                open;     // new voice opened
      logic                clr_all;
   } voice_cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0]   last_end;
      logic                free_any;
      logic [VOICE_W-1:0]  free_idx;
      logic [OPEN_W-1:0]   voices_open;
   } voice_stat_type;

endpackage

`default_nettype wire

[rtl/mnvs_pitch_tbl.sv]
`default_nettype none

module mnvs_pitch_tbl (
   input  wire                      clock,
   input  wire                      reset,
   input  mnvs_pkg::pitch_cmd_type  cmd,
   output mnvs_pkg::pitch_stat_type stat
);

   localparam int ENT_W = mnvs_pkg::VOICE_W + mnvs_pkg::TIME_W;

   logic [mnvs_pkg::PITCHES-1:0] valid_ff;
   logic [mnvs_pkg::PITCHES-1:0] valid_in;
   logic [ENT_W-1:0]             mem [mnvs_pkg::PITCHES];
   logic [ENT_W-1:0]             rd_ff;

   // held marks: flip-flops, cleared at once
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr_all) begin
         valid_in = '0;
      end else if (cmd.set) begin
         valid_in[cmd.addr] = 1'b1;
      end else if (cmd.clr) begin
         valid_in[cmd.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // voice and start time per pitch, registered read
   always_ff @(posedge clock) begin
      if (cmd.set) begin
         mem[cmd.addr] <= {cmd.wr_voice, cmd.wr_start};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.addr];
      end
   end

   assign stat.valid = valid_ff[cmd.addr];
   assign stat.voice = rd_ff[ENT_W-1 -: mnvs_pkg::VOICE_W];
   assign stat.start = rd_ff[mnvs_pkg::TIME_W-1:0];

endmodule

`default_nettype wire

[rtl/mnvs_voice_tbl.sv]
`default_nettype none

module mnvs_voice_tbl (
   input  wire                      clock,
   input  wire                      reset,
   input  mnvs_pkg::voice_cmd_type  cmd,
   output mnvs_pkg::voice_stat_type stat
);

   logic [mnvs_pkg::TIME_W-1:0]  mem [mnvs_pkg::VOICES];
   logic [mnvs_pkg::TIME_W-1:0]  rd_ff;

   logic [mnvs_pkg::VOICES-1:0]  free_ff;
   logic [mnvs_pkg::VOICES-1:0]  free_in;
   logic [mnvs_pkg::OPEN_W-1:0]  open_ff;
   logic [mnvs_pkg::OPEN_W-1:0]  open_in;

   logic [mnvs_pkg::GROUPS-1:0]  grp_any_ff;
   logic [mnvs_pkg::GROUPS-1:0]  grp_any_in;
   logic [mnvs_pkg::LIDX_W-1:0]  grp_low_ff [mnvs_pkg::GROUPS];
   logic [mnvs_pkg::LIDX_W-1:0]  grp_low_in [mnvs_pkg::GROUPS];
   logic [mnvs_pkg::GIDX_W-1:0]  grp_sel;

   // last end time per voice, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   // free map and open count
   always_comb begin
      free_in = free_ff;
      open_in = open_ff;
      if (cmd.clr_all) begin
         free_in = '0;
         open_in = '0;
      end else begin
         if (cmd.take) begin
            free_in[cmd.wr_addr] = 1'b0;
         end
         if (cmd.give) begin
            free_in[cmd.wr_addr] = 1'b1;
         end
         if (cmd.open) begin
            open_in = open_ff + 1'b1;
         end
      end
   end

   // first search level: lowest free voice in each group of eight
   always_comb begin
      for (int g = 0; g < mnvs_pkg::GROUPS; g++) begin
         grp_any_in[g] = |free_ff[g*mnvs_pkg::GROUP_SIZE +: mnvs_pkg::GROUP_SIZE];
         grp_low_in[g] = '0;
         for (int l = mnvs_pkg::GROUP_SIZE - 1; l >= 0; l--) begin
            if (free_ff[g*mnvs_pkg::GROUP_SIZE + l]) begin
               grp_low_in[g] = mnvs_pkg::LIDX_W'(l);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff    <= '0;
         open_ff    <= '0;
         grp_any_ff <= '0;
      end else begin
         free_ff    <= free_in;
         open_ff    <= open_in;
         grp_any_ff <= grp_any_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < mnvs_pkg::GROUPS; g++) begin
         grp_low_ff[g] <= grp_low_in[g];
      end
   end

   // second level: lowest group holding a free voice
   always_comb begin
      grp_sel = '0;
      for (int g = mnvs_pkg::GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            grp_sel = mnvs_pkg::GIDX_W'(g);
         end
      end
   end

   assign stat.last_end    = rd_ff;
   assign stat.free_any    = |grp_any_ff;
   assign stat.free_idx    = {grp_sel, grp_low_ff[grp_sel]};
   assign stat.voices_open = open_ff;

endmodule

`default_nettype wire

[rtl/mnvs_out_queue.sv]
`default_nettype none

module mnvs_out_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire [1:0]          push_n,
   input  mnvs_pkg::rec_type  push0,
   input  mnvs_pkg::rec_type  push1,
   output logic [1:0]         room,
   output logic               out_valid,
   input  wire                out_ready,
   output mnvs_pkg::rec_type  out_rec
);

   mnvs_pkg::rec_type ent_ff [2];
   logic              rp_ff;
   logic              rp_in;
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic              wp;
   logic              pop;

   assign pop       = out_valid & out_ready;
   assign wp        = rp_ff ^ cnt_ff[0];
   assign out_valid = (cnt_ff != 2'd0);
   assign out_rec   = ent_ff[rp_ff];
   assign room      = 2'd2 - cnt_ff;

   always_comb begin
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + push_n - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // two beats land in one cycle only when the queue is empty
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         ent_ff[wp] <= push0;
      end
      if (push_n == 2'd2) begin
         ent_ff[~wp] <= push1;
      end
   end

endmodule

`default_nettype wire

[rtl/midi_note_voice_splitter_top.sv]
// Channel | Direction | Beat contents (lowest bits first)
// req     | in        | tuser: kind; tdata: delta_ticks, pitch, velocity, tempo_value
// rsp     | out       | tuser: record_kind; tdata: voice, note_pitch, length_ticks,
//         |           | tempo_now; tlast: last
//
// An event passes three steps: accept, pitch table read, voice table read with
// commit; the next event is taken the cycle after commit. The dependent read of
// the voice table after the pitch table sets this.
// Events after end of track are accepted and swallowed without a table pass.
// Reset is synchronous; held marks and the voice map clear at once, no sweep.
// Commit waits while the two-beat result queue lacks room for the event's beats.
`default_nettype none

module midi_note_voice_splitter_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // kind
   input  wire  [mnvs_pkg::KIND_W-1:0]         req_tuser,
   // delta_ticks, pitch, velocity, tempo_value, zero pad
   input  wire  [mnvs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // record_kind
   output logic [mnvs_pkg::RKIND_W-1:0]        rsp_tuser,
   // voice, note_pitch, length_ticks, tempo_now, zero pad
   output logic [mnvs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

`include "midi_note_voice_splitter_top_defines.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PITCH = 2'd1;
   localparam logic [1:0] ST_VOICE = 2'd2;

   localparam int P_LO = mnvs_pkg::DELTA_W;
   localparam int V_LO = P_LO + mnvs_pkg::PITCH_W;
   localparam int T_LO = V_LO + mnvs_pkg::VEL_W;

   logic [1:0]                     state_ff, state_in;
   logic                           finished_ff, finished_in;
   logic [mnvs_pkg::TIME_W-1:0]    time_ff, time_in;
   logic [mnvs_pkg::TEMPO_W-1:0]   tempo_ff, tempo_in;

   logic [mnvs_pkg::KIND_W-1:0]    kind_ff;
   logic [mnvs_pkg::PITCH_W-1:0]   pitch_ff;
   logic [mnvs_pkg::VEL_W-1:0]     vel_ff;
   logic [mnvs_pkg::TEMPO_W-1:0]   tval_ff;

   logic [mnvs_pkg::DELTA_W-1:0]   req_delta;
   logic [mnvs_pkg::PITCH_W-1:0]   req_pitch;
   logic [mnvs_pkg::VEL_W-1:0]     req_vel;
   logic [mnvs_pkg::TEMPO_W-1:0]   req_tval;
   logic                           accept;
   logic                           take_item;

   mnvs_pkg::pitch_cmd_type        pcmd;
   mnvs_pkg::pitch_stat_type       pstat;
   mnvs_pkg::voice_cmd_type        vcmd;
   mnvs_pkg::voice_stat_type       vstat;

   logic                           is_rel, is_on, rel_ok, on_ok, rest, new_voice;
   logic                           is_tempo, is_end, commit;
   logic [mnvs_pkg::VOICE_W-1:0]   v_alloc;
   logic [mnvs_pkg::TEMPO_W-1:0]   tempo_out;
   logic [1:0]                     beats;
   logic [1:0]                     push_n;
   logic [1:0]                     q_room;
   mnvs_pkg::rec_type              rec0, rec1, rec_note, rec_rest, out_rec;

   // input beat fields
   assign req_delta = req_tdata[mnvs_pkg::DELTA_W-1:0];
   assign req_pitch = req_tdata[P_LO +: mnvs_pkg::PITCH_W];
   assign req_vel   = req_tdata[V_LO +: mnvs_pkg::VEL_W];
   assign req_tval  = req_tdata[T_LO +: mnvs_pkg::TEMPO_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign take_item  = accept & ~finished_ff;

   // event decode in the commit cycle
   assign is_rel   = (kind_ff == mnvs_pkg::KIND_NOTE_OFF) ||
                     ((kind_ff == mnvs_pkg::KIND_NOTE_ON) && (vel_ff == '0));
   assign is_on    = (kind_ff == mnvs_pkg::KIND_NOTE_ON) && (vel_ff != '0);
   assign is_tempo = (kind_ff == mnvs_pkg::KIND_TEMPO);
   assign is_end   = (kind_ff == mnvs_pkg::KIND_END);
   assign rel_ok   = is_rel && pstat.valid;
   assign rest     = rel_ok && (vstat.last_end < pstat.start);
   assign new_voice = ~vstat.free_any;
   assign on_ok    = is_on && !pstat.valid &&
                     (vstat.free_any || (vstat.voices_open < mnvs_pkg::OPEN_MAX));
   assign v_alloc  = vstat.free_any ? vstat.free_idx
                                    : vstat.voices_open[mnvs_pkg::VOICE_W-1:0];
   assign tempo_out = is_tempo ? tval_ff : tempo_ff;

   always_comb begin
      if (rel_ok) begin
         beats = rest ? 2'd2 : 2'd1;
      end else if (is_tempo || is_end) begin
         beats = 2'd1;
      end else begin
         beats = 2'd0;
      end
   end

   assign commit = (state_ff == ST_VOICE) && (beats <= q_room);
   assign push_n = commit ? beats : 2'd0;

   // result beats
   always_comb begin
      rec_rest.kind       = mnvs_pkg::REC_REST;
      rec_rest.voice      = pstat.voice;
      rec_rest.note_pitch = mnvs_pkg::REST_CODE;
      rec_rest.length     = pstat.start - vstat.last_end;
      rec_rest.tempo      = tempo_out;
      rec_rest.last       = 1'b0;

      rec_note.kind       = mnvs_pkg::REC_NOTE;
      rec_note.voice      = pstat.voice;
      rec_note.note_pitch = {1'b0, pitch_ff};
      rec_note.length     = time_ff - pstat.start;
      rec_note.tempo      = tempo_out;
      rec_note.last       = 1'b1;

      rec1 = rec_note;
      if (rel_ok) begin
         rec0 = rest ? rec_rest : rec_note;
      end else begin
         rec0.kind       = is_end ? mnvs_pkg::REC_END : mnvs_pkg::REC_TEMPO;
         rec0.voice      = '0;
         rec0.note_pitch = '0;
         rec0.length     = is_end ? time_ff : '0;
         rec0.tempo      = tempo_out;
         rec0.last       = 1'b1;
      end
   end

   // table commands
   always_comb begin
      pcmd          = '0;
      pcmd.rd_en    = take_item;
      pcmd.addr     = (state_ff == ST_IDLE) ? req_pitch : pitch_ff;
      pcmd.wr_voice = v_alloc;
      pcmd.wr_start = time_ff;

      vcmd          = '0;
      vcmd.rd_en    = (state_ff == ST_PITCH);
      vcmd.rd_addr  = pstat.voice;
      vcmd.wr_addr  = rel_ok ? pstat.voice : v_alloc;
      vcmd.wr_data  = rel_ok ? time_ff : '0;

      if (commit) begin
         if (on_ok) begin
            pcmd.set   = 1'b1;
            vcmd.take  = 1'b1;
            vcmd.open  = new_voice;
            vcmd.wr_en = new_voice;
         end
         if (rel_ok) begin
            pcmd.clr   = 1'b1;
            vcmd.give  = 1'b1;
            vcmd.wr_en = 1'b1;
         end
         if (is_end) begin
            pcmd.clr_all = 1'b1;
            vcmd.clr_all = 1'b1;
         end
      end
   end

   // sequencer and scalar state
   always_comb begin
      state_in    = state_ff;
      finished_in = finished_ff;
      time_in     = time_ff;
      tempo_in    = tempo_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_item) begin
               time_in  = time_ff + mnvs_pkg::TIME_W'(req_delta);
               state_in = ST_PITCH;
            end
         end
         ST_PITCH: begin
            state_in = ST_VOICE;
         end
         ST_VOICE: begin
            if (commit) begin
               state_in = ST_IDLE;
               if (is_tempo) begin
                  tempo_in = tval_ff;
               end
               if (is_end) begin
                  finished_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         finished_ff <= 1'b0;
         time_ff     <= '0;
         tempo_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         finished_ff <= finished_in;
         time_ff     <= time_in;
         tempo_ff    <= tempo_in;
      end
   end

   // event fields held for the table passes
   always_ff @(posedge clock) begin
      if (take_item) begin
         kind_ff  <= req_tuser;
         pitch_ff <= req_pitch;
         vel_ff   <= req_vel;
         tval_ff  <= req_tval;
      end
   end

   mnvs_pitch_tbl u_pitch_tbl (
      .clock (clock),
      .reset (reset),
      .cmd   (pcmd),
      .stat  (pstat)
   );

   mnvs_voice_tbl u_voice_tbl (
      .clock (clock),
      .reset (reset),
      .cmd   (vcmd),
      .stat  (vstat)
   );

   mnvs_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (rec0),
      .push1     (rec1),
      .room      (q_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   assign rsp_tuser = out_rec.kind;
   assign rsp_tdata = {1'b0, out_rec.tempo, out_rec.length, out_rec.note_pitch,
                       out_rec.voice};
   assign rsp_tlast = out_rec.last;

   // checks
   `MNVS_ASSERT(a_finish_sticky, finished_ff |=> finished_ff, "end of track flag dropped")
   `MNVS_ASSERT(a_finish_idle, finished_ff |-> (state_ff == ST_IDLE), "busy after track end")
   `MNVS_ASSERT(a_queue_room, (push_n != 2'd0) |-> (push_n <= q_room), "result queue overrun")
   `MNVS_ASSERT(a_open_bound, vstat.voices_open <= mnvs_pkg::OPEN_MAX, "too many voices open")
   `MNVS_ASSERT_RST(a_reset_idle, reset |=> ((state_ff == ST_IDLE) && !finished_ff), "reset missed")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import mnvs_pkg::*;

   localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_ERR_LINES = 100;

   // one track event as the sender sees it
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DELTA_W-1:0] delta;
      logic [PITCH_W-1:0] pitch;
      logic [VEL_W-1:0]   vel;
      logic [TEMPO_W-1:0] tv;
   } evt_type;

   // how a table row gets its expectation
   typedef enum logic [1:0] {BY_PREDICTOR, NO_RECORD, ONE_RECORD} row_check_type;

   typedef struct packed {
      evt_type       ev;
      row_check_type how;
      rec_type       exp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [KIND_W-1:0] req_tuser = '0;
   // delta_ticks, pitch, velocity, tempo_value, zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RKIND_W-1:0] rsp_tuser;
   // voice, note_pitch, length_ticks, tempo_now, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   midi_note_voice_splitter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // splitter state as predicted
   logic                 track_done = 1'b0;
   logic [TIME_W-1:0]    track_clock = '0;
   logic [TEMPO_W-1:0]   tempo_cur = '0;
   logic                 held_ok [PITCHES];
   logic [VOICE_W-1:0]   held_voice_of [PITCHES];
   logic [TIME_W-1:0]    note_start_at [PITCHES];
   logic [TIME_W-1:0]    voice_end_at [VOICES];
   logic                 voice_idle [VOICES];
   int                   open_count = 0;

   rec_type expected_recs [$];
   rec_type want;
   int err_count = 0;
   int cycle_count = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_start = 0;
   int hold_seen = 0;
   int stall_left = 0;

   initial begin
      for (int i = 0; i < PITCHES; i++) begin
         held_ok[i] = 1'b0;
         held_voice_of[i] = '0;
         note_start_at[i] = '0;
      end
      for (int i = 0; i < VOICES; i++) begin
         voice_end_at[i] = '0;
         voice_idle[i] = 1'b0;
      end
   end

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= MAX_ERR_LINES)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   // advance the predicted splitter by one event; queue its records if keep is set
   function automatic void predict_records(input evt_type e, input bit keep);
      rec_type got [$];
      rec_type r;
      logic [VOICE_W-1:0] v;
      logic [TIME_W-1:0] st;
      int slot;
      if (track_done)
         return;
      track_clock = track_clock + {4'd0, e.delta};
      case (e.kind)
         KIND_NOTE_ON, KIND_NOTE_OFF: begin
            if (e.kind == KIND_NOTE_OFF || e.vel == '0) begin
               // release: optional rest, then the note itself
               if (held_ok[e.pitch]) begin
                  v = held_voice_of[e.pitch];
                  st = note_start_at[e.pitch];
                  if (voice_end_at[v] < st)
                     got.push_back({REC_REST, v, REST_CODE, st - voice_end_at[v],
                                    tempo_cur, 1'b0});
                  got.push_back({REC_NOTE, v, {1'b0, e.pitch}, track_clock - st,
                                 tempo_cur, 1'b0});
                  voice_end_at[v] = track_clock;
                  held_ok[e.pitch] = 1'b0;
                  voice_idle[v] = 1'b1;
               end
            end else if (!held_ok[e.pitch]) begin
               // lowest free voice, else open one more
               slot = open_count;
               for (int i = 0; i < open_count; i++)
                  if (voice_idle[i]) begin
                     slot = i;
                     break;
                  end
               if (slot < VOICES) begin
                  if (slot == open_count) begin
                     open_count++;
                     voice_end_at[slot] = '0;
                  end
                  voice_idle[slot] = 1'b0;
                  held_ok[e.pitch] = 1'b1;
                  held_voice_of[e.pitch] = 7'(slot);
                  note_start_at[e.pitch] = track_clock;
               end
            end
         end
         KIND_TEMPO: begin
            tempo_cur = e.tv;
            got.push_back({REC_TEMPO, 7'd0, 8'd0, 32'd0, tempo_cur, 1'b0});
         end
         KIND_END: begin
            for (int i = 0; i < PITCHES; i++)
               held_ok[i] = 1'b0;
            for (int i = 0; i < VOICES; i++)
               voice_idle[i] = 1'b0;
            open_count = 0;
            track_done = 1'b1;
            got.push_back({REC_END, 7'd0, 8'd0, track_clock, tempo_cur, 1'b0});
         end
         default: ;
      endcase
      if (got.size() > 0) begin
         r = got.pop_back();
         r.last = 1'b1;
         got.push_back(r);
      end
      if (keep)
         foreach (got[i])
            expected_recs.push_back(got[i]);
   endfunction

   function automatic evt_type mk_evt(input logic [KIND_W-1:0] kind,
                                      input logic [DELTA_W-1:0] delta,
                                      input logic [PITCH_W-1:0] pitch,
                                      input logic [VEL_W-1:0] vel,
                                      input logic [TEMPO_W-1:0] tv);
      mk_evt = {kind, delta, pitch, vel, tv};
   endfunction

   function automatic plan_row_type plan_row(input evt_type ev, input row_check_type how,
                                             input rec_type exp);
      plan_row = {ev, how, exp};
   endfunction

   // mostly note traffic on a narrow pitch band, releases aimed at held pitches
   function automatic evt_type random_event();
      evt_type e;
      int pick;
      int d;
      int base;
      e = mk_evt(KIND_NOTE_ON, '0, 7'($urandom), 7'($urandom), 24'($urandom));
      d = $urandom_range(99);
      if (d < 65)
         e.delta = 28'($urandom_range(15));
      else if (d < 88)
         e.delta = 28'($urandom_range(4095));
      else if (d < 97)
         e.delta = 28'($urandom);
      else
         e.delta = 28'hFFFFFFF;
      pick = $urandom_range(99);
      if (pick < 45) begin
         e.kind = KIND_NOTE_ON;
         if ($urandom_range(9) != 0)
            e.pitch = 7'(52 + $urandom_range(23));
         e.vel = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
      end else if (pick < 80) begin
         e.kind = KIND_NOTE_OFF;
         base = $urandom_range(PITCHES - 1);
         for (int i = 0; i < PITCHES; i++)
            if (held_ok[(base + i) % PITCHES]) begin
               e.pitch = 7'((base + i) % PITCHES);
               break;
            end
         if ($urandom_range(1) == 0) begin
            e.kind = KIND_NOTE_ON;
            e.vel = '0;
         end
      end else if (pick < 88) begin
         e.kind = KIND_TEMPO;
      end else if (pick < 95) begin
         e.kind = KIND_OTHER + 3'($urandom_range(3));
      end else begin
         e.kind = KIND_NOTE_OFF;
      end
      return e;
   endfunction

   // offer one beat after an optional gap; predict once it is taken
   task automatic send_event(input evt_type e, input row_check_type how,
                             input rec_type exp);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= e.kind;
      req_tdata <= {6'd0, e.tv, e.vel, e.pitch, e.delta};
      do @(posedge clock); while (!req_tready);
      predict_records(e, how == BY_PREDICTOR);
      if (how == ONE_RECORD)
         expected_recs.push_back(exp);
   endtask

   // always moves past the current edge so the next beat is driven in a later step
   task automatic wait_records_out();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_recs.size() != 0);
   endtask

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_seen != hold_start) begin
         hold_seen <= hold_start;
         stall_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_recs.size() == 0) begin
            flag_error($sformatf("unexpected beat, record_kind %0d", rsp_tuser));
         end else begin
            want = expected_recs.pop_front();
            if (rsp_tuser !== want.kind)
               flag_error($sformatf("record_kind %0d, want %0d", rsp_tuser, want.kind));
            if (rsp_tdata[6:0] !== want.voice)
               flag_error($sformatf("voice %0d, want %0d", rsp_tdata[6:0], want.voice));
            if (rsp_tdata[14:7] !== want.note_pitch)
               flag_error($sformatf("note_pitch %0d, want %0d", rsp_tdata[14:7],
                                    want.note_pitch));
            if (rsp_tdata[46:15] !== want.length)
               flag_error($sformatf("length_ticks %0h, want %0h", rsp_tdata[46:15],
                                    want.length));
            if (rsp_tdata[70:47] !== want.tempo)
               flag_error($sformatf("tempo_now %0h, want %0h", rsp_tdata[70:47],
                                    want.tempo));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last %0b, want %0b", rsp_tlast, want.last));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      plan_row_type dir_plan [$];
      plan_row_type tail_plan [$];
      int order [PITCHES];
      int j;
      int t;

      // directed rows: extremes, every kind but end of track, the ignored cases
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 0, 5, 0, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_TEMPO, 0, 0, 0, 24'hFFFFFF), ONE_RECORD,
                                  {REC_TEMPO, 7'd0, 8'd0, 32'd0, 24'hFFFFFF, 1'b1}));
      dir_plan.push_back(plan_row(mk_evt(KIND_OTHER, 28'hFFFFFFF, 7'h7F, 7'h7F, 24'hFFFFFF),
                                  NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(3'd7, 0, 0, 0, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 0, 127, 127, 0), NO_RECORD, '0));
      // same pitch again while held
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 0, 127, 1, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 100, 0, 64, 0), NO_RECORD, '0));
      // velocity zero releases; both voices rest first
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 28'hFFFFFFF, 127, 0, 0),
                                  BY_PREDICTOR, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 5, 0, 0, 0), BY_PREDICTOR, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 0, 10, 127, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 0, 10, 0, 0), BY_PREDICTOR, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 0, 10, 0, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 0, 64, 0, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_TEMPO, 7, 0, 0, 0), ONE_RECORD,
                                  {REC_TEMPO, 7'd0, 8'd0, 32'd0, 24'd0, 1'b1}));
      dir_plan.push_back(plan_row(mk_evt(3'd5, 28'hFFFFFFF, 0, 0, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(3'd6, 28'hFFFFFFF, 0, 0, 0), NO_RECORD, '0));
      // two overlapping notes, then back-to-back notes with no gap
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 3, 33, 127, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 0, 34, 127, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 9, 33, 0, 0), BY_PREDICTOR, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 0, 35, 99, 0), NO_RECORD, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 28'hFFFFFFF, 34, 0, 0),
                                  BY_PREDICTOR, '0));
      dir_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 1, 35, 0, 0), BY_PREDICTOR, '0));

      // end of track with a note still held, then everything is ignored
      tail_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 9, 1, 5, 0), BY_PREDICTOR, '0));
      tail_plan.push_back(plan_row(mk_evt(KIND_END, 12345, 0, 0, 0), BY_PREDICTOR, '0));
      tail_plan.push_back(plan_row(mk_evt(KIND_NOTE_OFF, 1, 1, 0, 0), NO_RECORD, '0));
      tail_plan.push_back(plan_row(mk_evt(KIND_TEMPO, 0, 0, 0, 123), NO_RECORD, '0));
      tail_plan.push_back(plan_row(mk_evt(KIND_NOTE_ON, 4, 2, 10, 0), NO_RECORD, '0));
      tail_plan.push_back(plan_row(mk_evt(KIND_OTHER, 2, 0, 0, 0), NO_RECORD, '0));
      tail_plan.push_back(plan_row(mk_evt(KIND_END, 6, 0, 0, 0), NO_RECORD, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender mostly busy, receiver mostly stalled
      snd_idle_pct = 28;
      rcv_idle_pct = 88;
      foreach (dir_plan[i])
         send_event(dir_plan[i].ev, dir_plan[i].how, dir_plan[i].exp);
      repeat (150) send_event(random_event(), BY_PREDICTOR, '0);
      wait_records_out();

      // roles swapped
      snd_idle_pct = 88;
      rcv_idle_pct = 28;
      repeat (100) send_event(random_event(), BY_PREDICTOR, '0);
      wait_records_out();

      // no idling; long receiver hold-off while beats keep coming
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_start = hold_start + 1;
      repeat (50) send_event(random_event(), BY_PREDICTOR, '0);

      // hold every pitch at once so all voices open, then release in random order
      for (int i = 0; i < PITCHES; i++) begin
         order[i] = i;
         send_event(mk_evt(KIND_NOTE_ON, 28'($urandom_range(3)), 7'(i),
                           7'($urandom_range(127, 1)), 24'($urandom)), BY_PREDICTOR, '0);
      end
      for (int i = PITCHES - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[i])
         send_event(mk_evt($urandom_range(1) ? KIND_NOTE_OFF : KIND_NOTE_ON,
                           28'($urandom_range(40)), 7'(order[i]), 7'd0, 24'($urandom)),
                    BY_PREDICTOR, '0);
      repeat (30) send_event(random_event(), BY_PREDICTOR, '0);

      foreach (tail_plan[i])
         send_event(tail_plan[i].ev, tail_plan[i].how, tail_plan[i].exp);
      wait_records_out();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_recs.size() != 0)
         flag_error($sformatf("%0d records never arrived", expected_recs.size()));
      if (err_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
